[sv/sorted_list_insert_remove_core_macros.svh]
// Assertion macros for the sorted list insert/remove core checker.
// Needs nothing else; the checker file pulls it in by `include.
`ifndef SORTED_LIST_INSERT_REMOVE_CORE_MACROS_SVH
`define SORTED_LIST_INSERT_REMOVE_CORE_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define SLQ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent in the cycle after the antecedent.
`define SLQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Checked through reset as well.
`define SLQ_ASSERT_RST(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/slq_pkg.sv]
// Package for the sorted list insert/remove core: widths, request codes, cell control.
// Depends on nothing; used by the interfaces, the cell and the top level.
`timescale 1ns / 1ps

package slq_pkg;

   localparam int SLQ_CAPACITY = 64;
   localparam int DATA_W       = 32;
   localparam int COUNT_OUT_W  = 7;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   // Control broadcast to every cell of the chain.
   typedef struct packed {
      logic ins_en;
      logic rem_en;
   } slq_op_type;

endpackage

[sv/slq_if.sv]
// Valid/ready channel interfaces for requests and responses.
// Depends on slq_pkg.
`timescale 1ns / 1ps

interface slq_req_if;
   import slq_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     req_type;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output req_type, output value, input ready);
   modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface slq_rsp_if;
   import slq_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     done_ok;
   logic [COUNT_OUT_W-1:0]   entry_count;
   logic signed [DATA_W-1:0] largest_value;

   modport source (output valid, output done_ok, output entry_count,
                   output largest_value, input ready);
   modport sink   (input valid, input done_ok, input entry_count,
                   input largest_value, output ready);
endinterface

[sv/sorted_list_insert_remove_core.sv]
// A request is latched, then the whole cell chain compares, shifts and updates the count
// and the result register is loaded; the next request is taken once the chain has updated.
// A waiting result stalls the update cycle; one further request can be latched meanwhile,
// after which ready stays low until the waiting result is taken.
// Reset (synchronous, active high) empties the list, clears the request latch and drops the response valid.
`timescale 1ns / 1ps

module sorted_list_insert_remove_core #(
   parameter int CAPACITY = slq_pkg::SLQ_CAPACITY
) (
   input  logic       clock,
   input  logic       reset,
   slq_req_if.sink    req_chan,
   slq_rsp_if.source  rsp_chan
);
   import slq_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   // Latched request, held while the chain works on it.
   logic                     busy_ff;
   logic                     busy_in;
   logic                     kind_ff;
   logic signed [DATA_W-1:0] key_ff;

   // Stored count and the result register.
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic                     done_ok_ff;

   logic                     exec;
   logic                     full;
   logic                     found;
   logic                     ins_ok;
   logic                     rem_ok;
   slq_op_type               op;

   logic [CAPACITY-1:0]      gt_vec;
   logic [CAPACITY-1:0]      hit_vec;
   logic signed [DATA_W-1:0] val_vec [CAPACITY];

   // A request is taken whenever no request sits in the latch.
   assign req_chan.ready = !busy_ff;

   // The chain updates once the result register is free or is being emptied.
   assign exec  = busy_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign full  = count_ff == CNT_W'(CAPACITY);

   // With descending order, a matching copy exists exactly when some occupied cell
   // equals the key; the first cell not greater than the key is then that copy.
   assign found  = |hit_vec;
   assign ins_ok = exec && (kind_ff == REQ_INSERT) && !full;
   assign rem_ok = exec && (kind_ff == REQ_REMOVE) && found;
   assign op.ins_en = ins_ok;
   assign op.rem_en = rem_ok;

   // The chain of cells: each one sees the value to its left for an insert and the
   // value to its right for a remove.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                     left_gt;
      logic signed [DATA_W-1:0] left_val;
      logic signed [DATA_W-1:0] right_val;

      if (i == 0) begin : g_head
         assign left_gt  = 1'b1;
         assign left_val = key_ff;
      end else begin : g_body
         assign left_gt  = gt_vec[i-1];
         assign left_val = val_vec[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_val = val_vec[i];
      end else begin : g_inner
         assign right_val = val_vec[i+1];
      end

      slq_cell #(
         .IDX   (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock     (clock),
         .op        (op),
         .key       (key_ff),
         .count     (count_ff),
         .left_gt   (left_gt),
         .left_val  (left_val),
         .right_val (right_val),
         .gt        (gt_vec[i]),
         .hit       (hit_vec[i]),
         .val       (val_vec[i])
      );
   end

   always_comb begin
      busy_in = busy_ff;
      if (exec) begin
         busy_in = 1'b0;
      end else if (req_chan.valid && !busy_ff) begin
         busy_in = 1'b1;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ins_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (rem_ok) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request latch and status flag carry payload only.
   always_ff @(posedge clock) begin
      if (req_chan.valid && !busy_ff) begin
         kind_ff <= req_chan.req_type;
         key_ff  <= req_chan.value;
      end
      if (exec) begin
         done_ok_ff <= ins_ok || rem_ok;
      end
   end

   // The count and cell 0 only change in an update cycle, which needs the result
   // register free, so they read straight out as the response payload.
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.done_ok       = done_ok_ff;
   assign rsp_chan.entry_count   = COUNT_OUT_W'(count_ff);
   assign rsp_chan.largest_value = (count_ff != '0) ? val_vec[0] : '0;

endmodule

[sv/slq_cell.sv]
// One slot of the sorted chain: holds a value, compares it and shifts with its neighbors.
// Depends on slq_pkg.
`timescale 1ns / 1ps

module slq_cell #(
   parameter int IDX   = 0,
   parameter int CNT_W = 7
) (
   input  logic                              clock,
   input  slq_pkg::slq_op_type               op,
   input  logic signed [slq_pkg::DATA_W-1:0] key,
   input  logic [CNT_W-1:0]                  count,
   input  logic                              left_gt,
   input  logic signed [slq_pkg::DATA_W-1:0] left_val,
   input  logic signed [slq_pkg::DATA_W-1:0] right_val,
   output logic                              gt,
   output logic                              hit,
   output logic signed [slq_pkg::DATA_W-1:0] val
);
   import slq_pkg::*;

   logic signed [DATA_W-1:0] val_ff;
   logic signed [DATA_W-1:0] val_in;
   logic                     occupied;

   // The chain is kept in descending order, so cell 0 holds the largest value.
   assign occupied = CNT_W'(IDX) < count;
   assign gt       = occupied && (val_ff > key);
   assign hit      = occupied && (val_ff == key);
   assign val      = val_ff;

   always_comb begin
      val_in = val_ff;
      if (op.ins_en && !gt) begin
         val_in = left_gt ? key : left_val;
      end else if (op.rem_en && !gt) begin
         val_in = right_val;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

[sv/slq_checker.sv]
// Port-level checker for the sorted list insert/remove core, bound to the top level.
// Depends on slq_pkg and sorted_list_insert_remove_core_macros.svh.
`timescale 1ns / 1ps
`include "sorted_list_insert_remove_core_macros.svh"

module slq_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              done_ok,
   input logic [slq_pkg::COUNT_OUT_W-1:0]   entry_count,
   input logic signed [slq_pkg::DATA_W-1:0] largest_value
);
   import slq_pkg::*;

   // A request transfer leaves ready low in the cycle after it.
   `SLQ_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "ready stayed high after a request transfer")

   // A stalled response keeps its payload.
   `SLQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(done_ok) && $stable(entry_count) && $stable(largest_value), "stalled response changed")

   // An empty list reports zero as its largest value.
   `SLQ_ASSERT_NOW(a_empty_zero, clock, reset, rsp_valid && (entry_count == '0), largest_value == '0, "empty list reported a nonzero largest value")

   // Reset leaves no response pending and the request side open.
   `SLQ_ASSERT_RST(a_reset_idle, clock, reset, !rsp_valid && req_ready, "handshakes not idle after reset")

endmodule

bind sorted_list_insert_remove_core slq_checker u_slq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .done_ok       (rsp_chan.done_ok),
   .entry_count   (rsp_chan.entry_count),
   .largest_value (rsp_chan.largest_value)
);
